FILE: rtl/alm_pkg.sv
// ----------------------------------------------------------------------------
// ASCII-art luma mapper package
// Shared constants, the character ramp and the control struct that the
// top level hands to the quantizer.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int unsigned RgbW      = 8;
  localparam int unsigned LumaW     = 24;
  localparam int unsigned SumW      = 25;
  localparam int unsigned ScaledW   = 32;
  localparam int unsigned CharW     = 7;
  localparam int unsigned IdxW      = 7;
  localparam int unsigned WidthW    = 11;
  localparam int unsigned HeightW   = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 12;

  // Luma weights in Q0.16; they sum to 65536.
  localparam logic [15:0] LUMA_WR = 16'd19595;
  localparam logic [15:0] LUMA_WG = 16'd38470;
  localparam logic [15:0] LUMA_WB = 16'd7471;

  // Index of the last ramp character and the rounding bias (255 * 65536).
  localparam logic [IdxW-1:0]    RAMP_LAST  = 7'd69;
  localparam logic [ScaledW-1:0] ROUND_BIAS = 32'd16711680;

  localparam logic [CharW-1:0] CHAR_NEWLINE = 7'd10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WidthW-1:0]  WIDTH_RESET  = 11'd80;
  localparam logic [HeightW-1:0] HEIGHT_RESET = 12'd48;

  // Seventy-character ramp from darkest to lightest glyph.
  localparam logic [CharW-1:0] RAMP_CHARS [0:69] = '{
    7'd36,  7'd64,  7'd66,  7'd37,  7'd56,  7'd38,  7'd87,  7'd77,  7'd35,  7'd42,
    7'd111, 7'd97,  7'd104, 7'd107, 7'd98,  7'd100, 7'd112, 7'd113, 7'd119, 7'd109,
    7'd90,  7'd79,  7'd48,  7'd81,  7'd76,  7'd67,  7'd74,  7'd85,  7'd89,  7'd88,
    7'd122, 7'd99,  7'd118, 7'd117, 7'd110, 7'd120, 7'd114, 7'd106, 7'd102, 7'd116,
    7'd47,  7'd92,  7'd124, 7'd40,  7'd41,  7'd49,  7'd123, 7'd125, 7'd91,  7'd93,
    7'd63,  7'd45,  7'd95,  7'd43,  7'd126, 7'd60,  7'd62,  7'd105, 7'd33,  7'd108,
    7'd73,  7'd59,  7'd58,  7'd44,  7'd34,  7'd94,  7'd96,  7'd39,  7'd46,  7'd32
  };

  typedef struct packed {
    logic load_sum;
    logic load_scale;
    logic load_index;
  } quant_ctrl_t;

endpackage

FILE: rtl/alm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// Synchronous write and a registered read.
// ----------------------------------------------------------------------------
module alm_ram #(
  parameter int unsigned DataW = 24,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [0:Depth-1];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/alm_luma.sv
// ----------------------------------------------------------------------------
// Luma unit
// Registers the three weighted color products; their sum is the Q8.16 luma.
// ----------------------------------------------------------------------------
module alm_luma
  import alm_pkg::*;
(
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [RgbW-1:0]   red_i,
  input  logic [RgbW-1:0]   green_i,
  input  logic [RgbW-1:0]   blue_i,
  output logic [LumaW-1:0]  luma_o
);

  logic [LumaW-1:0] prod_r_q, prod_g_q, prod_b_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_r_q <= LumaW'(red_i)   * LumaW'(LUMA_WR);
      prod_g_q <= LumaW'(green_i) * LumaW'(LUMA_WG);
      prod_b_q <= LumaW'(blue_i)  * LumaW'(LUMA_WB);
    end
  end

  // The weights sum to 65536, so the total never exceeds 255 * 65536.
  assign luma_o = prod_r_q + prod_g_q + prod_b_q;

endmodule

FILE: rtl/alm_quant.sv
// ----------------------------------------------------------------------------
// Ramp quantizer
// Turns the two-row luma sum into a ramp index over three registered steps
// and looks up the character.
// ----------------------------------------------------------------------------
module alm_quant
  import alm_pkg::*;
(
  input  logic              clk_i,
  input  quant_ctrl_t       ctrl_i,
  input  logic [LumaW-1:0]  stored_luma_i,
  input  logic [LumaW-1:0]  luma_i,
  output logic [CharW-1:0]  char_code_o
);

  logic [SumW-1:0]    sum_q;
  logic [ScaledW-1:0] scaled_q;
  logic [IdxW-1:0]    index_q;

  logic [14:0]     quot_in;
  logic [IdxW-1:0] quot_lo;
  logic [14:0]     rem;
  logic [IdxW-1:0] quot;
  logic [IdxW-1:0] index_d;

  // Index is floor(scaled / (2^17 * 255)). The shift leaves a value under
  // 2^15; dividing that by 255 via a divide by 256 needs at most one
  // correction step.
  always_comb begin
    quot_in = scaled_q[ScaledW-1:17];
    quot_lo = quot_in[14:8];
    rem     = quot_in - ({quot_lo, 8'h00} - 15'(quot_lo));
    quot    = (rem >= 15'd255) ? quot_lo + 7'd1 : quot_lo;
    index_d = (quot > RAMP_LAST) ? RAMP_LAST : quot;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_sum) begin
      sum_q <= SumW'(stored_luma_i) + SumW'(luma_i);
    end
    if (ctrl_i.load_scale) begin
      scaled_q <= ScaledW'(sum_q) * ScaledW'(RAMP_LAST) + ROUND_BIAS;
    end
    if (ctrl_i.load_index) begin
      index_q <= index_d;
    end
  end

  assign char_code_o = RAMP_CHARS[index_q];

endmodule

FILE: rtl/ascii_art_luma_mapper_unit.sv
// ----------------------------------------------------------------------------
// ASCII-art luma mapper unit
// Converts a raster stream of RGB pixels into lines of ramp characters, one
// text line for each pair of pixel rows, with a newline after each line.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   -------  ---------  ---------------------  ----------------------------------
//   in       sink       in_valid_i/in_stall_o  red_i, green_i, blue_i
//   out      source     out_valid_o/out_stall_i char_code_o, last_of_run_o,
//                                              frame_end_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A pixel of the first row of a pair, or of a trailing odd row, passes through S_LUMA only.
// A pixel of the second row passes through S_LUMA, S_SCALE, S_DIV and S_CHAR, then
// S_NL when it closes the line and a newline follows; S_CHAR and S_NL wait on output stalls.
// These steps are set by the read-modify-write of the column line buffer and the
// three-step ramp quantizer, which the block runs for one pixel at a time.
// The line buffer needs no clearing after reset, so the block takes pixels as soon
// as reset is released.
// ----------------------------------------------------------------------------
module ascii_art_luma_mapper_unit
  import alm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [RgbW-1:0]     red_i,
  input  logic [RgbW-1:0]     green_i,
  input  logic [RgbW-1:0]     blue_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CharW-1:0]    char_code_o,
  output logic                last_of_run_o,
  output logic                frame_end_o,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Column address width; a single-column buffer still gets one address bit.
  localparam int unsigned AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CmpW  = 13;
  localparam logic [CmpW-1:0] MaxWidthC = CmpW'(MAX_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LUMA,
    S_SCALE,
    S_DIV,
    S_CHAR,
    S_NL
  } state_e;

  state_e state_q;

  // Configuration registers. Write them only while idle; the block does not check.
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i[WidthW-1:0];
      end else if (cfg_index_i == REG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i[HeightW-1:0];
      end
    end
  end

  // Effective frame geometry: the width is clamped to one through MAX_WIDTH,
  // and the height to at least two. Only whole row pairs produce text.
  logic [CmpW-1:0] width_eff;
  logic [CmpW-1:0] height_eff;
  logic [CmpW-1:0] pair_rows;

  always_comb begin
    if (width_q == '0) begin
      width_eff = CmpW'(1);
    end else if (CmpW'(width_q) > MaxWidthC) begin
      width_eff = MaxWidthC;
    end else begin
      width_eff = CmpW'(width_q);
    end
    height_eff = (height_q < 12'd2) ? CmpW'(2) : CmpW'(height_q);
    pair_rows  = {height_eff[CmpW-1:1], 1'b0};
  end

  // Position counters and the decisions taken when a pixel is accepted.
  logic [AddrW-1:0]   col_q;
  logic [HeightW-1:0] row_q;
  logic               in_xfer;
  logic [CmpW-1:0]    col_next;
  logic [CmpW-1:0]    row_next;
  logic               row_end;
  logic               frame_wrap;
  logic               in_pairs;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    col_next   = CmpW'(col_q) + CmpW'(1);
    row_next   = CmpW'(row_q) + CmpW'(1);
    row_end    = (col_next >= width_eff);
    frame_wrap = row_end && (row_next >= height_eff);
    in_pairs   = (CmpW'(row_q) < pair_rows);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_wrap ? '0 : row_next[HeightW-1:0];
      end else begin
        col_q <= col_next[AddrW-1:0];
      end
    end
  end

  // Per-pixel job flags, held while the pixel works its way through.
  logic             store_q;     // first row of a pair: write luma to buffer
  logic             produce_q;   // second row of a pair: emit a character
  logic             row_end_q;   // the pixel closes its text line
  logic             last_pair_q; // the text line is the frame's last
  logic [AddrW-1:0] addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q     <= 1'b0;
      produce_q   <= 1'b0;
      row_end_q   <= 1'b0;
      last_pair_q <= 1'b0;
    end else if (in_xfer) begin
      store_q     <= in_pairs && !row_q[0];
      produce_q   <= in_pairs && row_q[0];
      row_end_q   <= row_end;
      last_pair_q <= (row_next >= pair_rows);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      addr_q <= col_q;
    end
  end

  // Luma products are registered on the accepting edge; the buffer read of
  // the same column is issued on that edge too, so both are ready in S_LUMA.
  logic [LumaW-1:0] luma;
  logic [LumaW-1:0] stored_luma;

  alm_luma u_luma (
    .clk_i   (clk_i),
    .load_i  (in_xfer),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .luma_o  (luma)
  );

  // The write of a first-row pixel lands before the block takes the next
  // pixel, so a later read of the same column always sees it.
  alm_ram #(
    .DataW (LumaW),
    .Depth (MAX_WIDTH),
    .AddrW (AddrW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_LUMA) && store_q),
    .waddr_i (addr_q),
    .wdata_i (luma),
    .re_i    (in_xfer),
    .raddr_i (col_q),
    .rdata_o (stored_luma)
  );

  quant_ctrl_t      quant_ctrl;
  logic [CharW-1:0] ramp_char;

  always_comb begin
    quant_ctrl.load_sum   = (state_q == S_LUMA) && produce_q;
    quant_ctrl.load_scale = (state_q == S_SCALE);
    quant_ctrl.load_index = (state_q == S_DIV);
  end

  alm_quant u_quant (
    .clk_i         (clk_i),
    .ctrl_i        (quant_ctrl),
    .stored_luma_i (stored_luma),
    .luma_i        (luma),
    .char_code_o   (ramp_char)
  );

  // Sequencer and output register. The output register takes a new result
  // whenever it is empty or its current result leaves in this cycle.
  logic             out_valid_q;
  logic [CharW-1:0] char_code_q;
  logic             last_of_run_q;
  logic             frame_end_q;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      char_code_q   <= CHAR_NEWLINE;
      last_of_run_q <= 1'b0;
      frame_end_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_LUMA;
          end
        end
        S_LUMA: begin
          state_q <= produce_q ? S_SCALE : S_IDLE;
        end
        S_SCALE: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          state_q <= S_CHAR;
        end
        S_CHAR: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            char_code_q   <= ramp_char;
            last_of_run_q <= !row_end_q;
            frame_end_q   <= 1'b0;
            state_q       <= row_end_q ? S_NL : S_IDLE;
          end
        end
        S_NL: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            char_code_q   <= CHAR_NEWLINE;
            last_of_run_q <= 1'b1;
            frame_end_q   <= last_pair_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_code_o   = char_code_q;
  assign last_of_run_o = last_of_run_q;
  assign frame_end_o   = frame_end_q;

endmodule

FILE: rtl/alm_checker.sv
// ----------------------------------------------------------------------------
// ASCII-art luma mapper port checker
// Concurrent assertions on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
module alm_checker
  import alm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_o,
  input  logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic [CharW-1:0] char_code_o,
  input  logic             last_of_run_o,
  input  logic             frame_end_o
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_code_o)
      && $stable(last_of_run_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  // The frame end is flagged only on a newline that ends its pixel's results.
  a_frame_end_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> (char_code_o == CHAR_NEWLINE) && last_of_run_o)
    else $error("frame end on a result other than a final newline");

  // A result that leaves while not its pixel's last is a ramp character and carries no frame end.
  a_char_then_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |->
      (char_code_o != CHAR_NEWLINE) && !frame_end_o)
    else $error("non-final result is not a ramp character");

  // One pixel at a time: the block is busy right after taking a pixel.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second pixel taken while the first is in work");

endmodule

bind ascii_art_luma_mapper_unit alm_checker u_alm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .char_code_o   (char_code_o),
  .last_of_run_o (last_of_run_o),
  .frame_end_o   (frame_end_o)
);
